FILE: rtl/pcx_rle_encoder_defines.svh
// Assertion macros shared by the checkers of the run-length encoder.
// Both sample on clk and are disabled while rst_n is low.
`ifndef PCX_RLE_ENCODER_DEFINES_SVH
`define PCX_RLE_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge.
`define PRLE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pcx_rle_encoder check failed");

// A condition that must hold in the cycle after the antecedent.
`define PRLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcx_rle_encoder check failed");

`endif

FILE: rtl/prle_pkg.sv
`default_nettype none

package prle_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [5:0] RUN_MAX    = 6'd63;
  localparam logic [7:0] COUNT_BASE = 8'hC0;

  // Register index of always_pair.
  localparam logic REG_ALWAYS_PAIR = 1'b0;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } prle_in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       final_byte;
  } prle_out_t;

  // One finished run as handed from the front end to the back end.
  typedef struct packed {
    logic [7:0] value;
    logic [5:0] count;
    logic       pair;
    logic       fin;
  } prle_run_t;

  typedef enum logic {
    BK_HEAD,
    BK_DATA
  } prle_bk_state_t;

  function automatic prle_run_t prle_make_run(input logic [7:0] value,
                                              input logic [5:0] count,
                                              input logic       fin,
                                              input logic       always_pair);
    prle_run_t r;
    r.value = value;
    r.count = count;
    r.fin   = fin;
    r.pair  = always_pair || (count != 6'd1) || (value >= COUNT_BASE);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/prle_fifo.sv
`default_nettype none

module prle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  prle_pkg::prle_run_t  push_data,
  input  wire                  pop,
  output prle_pkg::prle_run_t  head,
  output logic                 empty,
  output logic                 full
);
  import prle_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  prle_run_t      mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    count_r, count_nxt;
  logic           do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/prle_front.sv
`default_nettype none

module prle_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  always_pair,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  prle_pkg::prle_in_t   in_data,
  output logic                 push,
  output prle_pkg::prle_run_t  push_data,
  input  wire                  q_full
);
  import prle_pkg::*;

  logic [7:0] held_r, held_nxt;
  logic [5:0] count_r, count_nxt;
  logic       pend_r, pend_nxt;
  logic       accept;
  logic       run_break;

  // While a closing run waits to be queued, no new pixel is taken.
  assign in_ready  = !pend_r && !q_full;
  assign accept    = in_valid && in_ready;
  assign run_break = (in_data.pixel != held_r) || (count_r == RUN_MAX);

  always_comb begin
    held_nxt  = held_r;
    count_nxt = count_r;
    pend_nxt  = pend_r;
    push      = 1'b0;
    push_data = prle_make_run(held_r, count_r, 1'b1, always_pair);
    if (pend_r) begin
      if (!q_full) begin
        push      = 1'b1;
        count_nxt = '0;
        pend_nxt  = 1'b0;
      end
    end else if (accept) begin
      if (count_r == '0) begin
        held_nxt  = in_data.pixel;
        count_nxt = 6'd1;
        if (in_data.last_pixel) begin
          push      = 1'b1;
          push_data = prle_make_run(in_data.pixel, 6'd1, 1'b1, always_pair);
          count_nxt = '0;
        end
      end else if (run_break) begin
        push      = 1'b1;
        push_data = prle_make_run(held_r, count_r, 1'b0, always_pair);
        held_nxt  = in_data.pixel;
        count_nxt = 6'd1;
        // The new one-pixel run is held in pend_r and closes the image once the queue has room.
        pend_nxt  = in_data.last_pixel;
      end else begin
        count_nxt = count_r + 6'd1;
        if (in_data.last_pixel) begin
          push      = 1'b1;
          push_data = prle_make_run(held_r, count_r + 6'd1, 1'b1, always_pair);
          count_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/prle_back.sv
`default_nettype none

module prle_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  prle_pkg::prle_run_t  head,
  input  wire                  q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output prle_pkg::prle_out_t  out_data
);
  import prle_pkg::*;

  prle_bk_state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  prle_out_t      out_data_r, out_data_nxt;
  logic           slot_free;
  logic           load;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_HEAD: begin
        if (slot_free && !q_empty && head.pair) begin
          state_nxt = BK_DATA;
        end
      end
      BK_DATA: begin
        if (slot_free) begin
          state_nxt = BK_HEAD;
        end
      end
      default: state_nxt = BK_HEAD;
    endcase
  end

  always_comb begin
    load                    = 1'b0;
    pop                     = 1'b0;
    out_data_nxt.code_byte  = head.value;
    out_data_nxt.final_byte = head.fin;
    unique case (state_r)
      BK_HEAD: begin
        if (slot_free && !q_empty) begin
          load = 1'b1;
          if (head.pair) begin
            out_data_nxt.code_byte  = COUNT_BASE + {2'b00, head.count};
            out_data_nxt.final_byte = 1'b0;
          end else begin
            pop = 1'b1;
          end
        end
      end
      BK_DATA: begin
        if (slot_free) begin
          load = 1'b1;
          pop  = 1'b1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pcx_rle_encoder.sv
// PCX run-length encoder for 8-bit palette-index pixels.
// Input channel (in_valid/in_ready/in_data): one pixel per item, last_pixel
// set on the final pixel of the image. Output channel (out_valid/out_ready/
// out_data): one encoded byte per item, final_byte set on the image's last byte.
// The APB port holds always_pair at addresses 0 to 3; it should be written while idle.
// A run is closed by a different pixel, a 64th equal pixel or the end of the
// image. The closing run is written to the run queue and its first byte then
// passes through the output register; a pair's data byte follows in the next free slot.
// The output register holds one byte: a run that goes out as a pair takes two
// output bytes, a literal takes one.
// The last pixel of an image that also breaks a run holds in_ready low
// while the second run is queued.
// A small run queue decouples the front end from the output, so pixels keep
// being accepted while the receiver stalls until the queue is full.
// Reset (rst_n low, synchronous) drops any held run, empties the queue and
// clears always_pair.
`default_nettype none

module pcx_rle_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [prle_pkg::PADDR_W-1:0]  paddr,
  input  wire  [prle_pkg::PDATA_W-1:0]  pwdata,
  output logic [prle_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  prle_pkg::prle_in_t            in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output prle_pkg::prle_out_t           out_data
);
  import prle_pkg::*;

  logic      always_pair_r, always_pair_nxt;
  logic      cfg_write;
  logic      push, pop, q_empty, q_full;
  prle_run_t push_data, head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {{(PDATA_W - 1){1'b0}}, always_pair_r};

  always_comb begin
    always_pair_nxt = always_pair_r;
    if (cfg_write && (paddr[PADDR_W-1] == REG_ALWAYS_PAIR)) begin
      always_pair_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      always_pair_r <= 1'b0;
    end else begin
      always_pair_r <= always_pair_nxt;
    end
  end

  prle_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .always_pair (always_pair_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push        (push),
    .push_data   (push_data),
    .q_full      (q_full)
  );

  prle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  prle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/prle_checker.sv
`default_nettype none

`include "pcx_rle_encoder_defines.svh"

module prle_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           psel,
  input wire                           penable,
  input wire                           pwrite,
  input wire [prle_pkg::PADDR_W-1:0]   paddr,
  input wire [prle_pkg::PDATA_W-1:0]   pwdata,
  input wire [prle_pkg::PDATA_W-1:0]   prdata,
  input wire                           pready,
  input wire                           out_valid,
  input wire                           out_ready,
  input prle_pkg::prle_out_t           out_data
);
  import prle_pkg::*;

  logic mode_write;

  assign mode_write = psel && penable && pwrite && pready &&
                      (paddr[PADDR_W-1] == REG_ALWAYS_PAIR);

  `PRLE_ASSERT_ALWAYS(a_pready_high, pready)
  `PRLE_ASSERT_ALWAYS(a_prdata_upper_zero, prdata[PDATA_W-1:1] == '0)
  `PRLE_ASSERT_NEXT(a_mode_written, mode_write, prdata[0] == $past(pwdata[0]))
  `PRLE_ASSERT_ALWAYS(a_no_output_after_reset, $past(rst_n) || !out_valid)
  `PRLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind pcx_rle_encoder prle_checker u_prle_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
  import prle_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_ALWAYS_PAIR = {REG_ALWAYS_PAIR, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE       = 3'd4;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 200000;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  prle_in_t           in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  prle_out_t          out_data;

  pcx_rle_encoder uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  prle_in_t   pixel_queue[$];
  prle_out_t  code_queue[$];
  prle_out_t  want;
  logic [7:0] run_value = '0;
  logic [5:0] run_len   = '0;
  logic       pair_mode = 1'b0;
  int         items_queued = 0;
  int         items_taken  = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  bit         calm = 1'b0;

  function automatic void push_code(input logic [7:0] b, input logic fin);
    code_queue.push_back(prle_out_t'{code_byte: b, final_byte: fin});
  endfunction

  // A lone byte below the count range goes out as itself unless every run
  // must be a pair.
  function automatic void queue_run(input logic fin);
    logic [7:0] count_byte;
    count_byte = COUNT_BASE + {2'b00, run_len};
    if (run_len == 6'd1 && run_value < COUNT_BASE && !pair_mode) begin
      push_code(run_value, fin);
    end else begin
      push_code(count_byte, 1'b0);
      push_code(run_value, fin);
    end
  endfunction

  function automatic void encode_pixel(input prle_in_t px);
    if (run_len == 6'd0) begin
      run_value = px.pixel;
      run_len   = 6'd1;
    end else if (px.pixel != run_value || run_len == RUN_MAX) begin
      queue_run(1'b0);
      run_value = px.pixel;
      run_len   = 6'd1;
    end else begin
      run_len = run_len + 6'd1;
    end
    if (px.last_pixel) begin
      queue_run(1'b1);
      run_len = 6'd0;
    end
  endfunction

  function automatic void add_pixel(input logic [7:0] p, input logic last);
    pixel_queue.push_back(prle_in_t'{pixel: p, last_pixel: last});
    items_queued++;
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 8'hBF : 8'hC0;
      1: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
      2: return 8'($urandom_range(0, 8'hBF));
      3: return 8'($urandom_range(8'hC0, 8'hFF));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly whole images built from runs, some of them long enough to hit
  // the count cap, mixed with loose pixels carrying random end flags.
  function automatic void add_random_items(input int count);
    int stop;
    int remaining;
    int len;
    logic [7:0] v;
    stop = items_queued + count;
    while (items_queued < stop) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) add_pixel(pick_pixel(), $urandom_range(0, 5) == 0);
      end else begin
        remaining = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80)
                                                : $urandom_range(1, 12);
        while (remaining > 0) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(62, 66) : $urandom_range(1, 4);
          if (len > remaining) len = remaining;
          v = pick_pixel();
          for (int k = 0; k < len; k++) begin
            add_pixel(v, (remaining == len) && (k == len - 1));
          end
          remaining -= len;
        end
      end
    end
  endfunction

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_ALWAYS_PAIR) pair_mode = data[0];
  endtask

  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_valid || code_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver: the prediction is made as each item is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_pixel(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          in_data  <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the run queue fills.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && items_taken >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (code_queue.size() == 0) begin
        $display("%0t: unexpected byte %02h final %0b", $time,
                 out_data.code_byte, out_data.final_byte);
        mismatches++;
      end else begin
        want = code_queue.pop_front();
        if (out_data.code_byte !== want.code_byte) begin
          $display("%0t: code_byte expected %02h, got %02h", $time,
                   want.code_byte, out_data.code_byte);
          mismatches++;
        end
        if (out_data.final_byte !== want.final_byte) begin
          $display("%0t: final_byte expected %0b, got %0b", $time,
                   want.final_byte, out_data.final_byte);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** pcx_rle_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Single-pixel images, literal limits and a last pixel that breaks a run.
    add_pixel(8'h00, 1'b1);
    add_pixel(8'hFF, 1'b1);
    add_pixel(8'hBF, 1'b0);
    add_pixel(8'hC0, 1'b0);
    add_pixel(8'h80, 1'b0);
    add_pixel(8'h80, 1'b0);
    add_pixel(8'h7F, 1'b1);
    add_pixel(8'hE0, 1'b0);
    add_pixel(8'hF5, 1'b1);
    add_pixel(8'h01, 1'b0);
    add_pixel(8'h01, 1'b1);
    add_pixel(8'h22, 1'b1);
    add_pixel(8'h22, 1'b1);
    add_pixel(8'hAA, 1'b0);
    add_pixel(8'h55, 1'b0);
    add_pixel(8'hC0, 1'b0);
    add_pixel(8'hC0, 1'b1);
    wait_drained();

    write_reg(ADDR_ALWAYS_PAIR, {31'($urandom), 1'b1});
    add_pixel(8'h00, 1'b1);
    add_pixel(8'h10, 1'b0);
    add_pixel(8'h10, 1'b0);
    add_pixel(8'h20, 1'b1);
    add_random_items(70);
    wait_drained();

    // A write beyond the register list must leave the pair mode alone.
    write_reg(ADDR_SPARE, 32'h0);
    add_random_items(40);
    wait_drained();

    write_reg(ADDR_ALWAYS_PAIR, {31'($urandom), 1'b0});
    add_random_items(50);
    while (pixel_queue.size() != 0) @(posedge clk);
    calm = 1'b1;
    add_random_items(40);
    wait_drained();

    if (mismatches == 0) begin
      $display("** pcx_rle_encoder: PASSED **");
    end else begin
      $display("** pcx_rle_encoder: FAILED **");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/prle_pkg.sv
rtl/prle_fifo.sv
rtl/prle_front.sv
rtl/prle_back.sv
rtl/pcx_rle_encoder.sv
rtl/prle_checker.sv
tb/sv/testbench.sv
